FILE: src/dos_pkg.sv
package dos_pkg;

  localparam int MAX_ENTRIES_DEFAULT = 64;
  localparam int HANDLE_W = 16;
  localparam int KEY_W    = 32;

  typedef struct packed {
    logic [HANDLE_W-1:0]    handle;
    logic signed [KEY_W-1:0] key;
    logic                   flag;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  // True when a stored entry must sit behind a newly arriving one.
  function automatic logic goes_after(entry_t stored, entry_t arriving);
    goes_after = (stored.key > arriving.key) ||
                 ((stored.key == arriving.key) && stored.flag && !arriving.flag);
  endfunction

endpackage

FILE: src/dos_in_if.sv
interface dos_in_if
  import dos_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [HANDLE_W-1:0]     handle;
  logic signed [KEY_W-1:0] depth_key;
  logic                    on_top;
  logic                    final_entry;

  modport source (output valid, handle, depth_key, on_top, final_entry, input ready);
  modport sink   (input valid, handle, depth_key, on_top, final_entry, output ready);
endinterface

FILE: src/dos_out_if.sv
interface dos_out_if
  import dos_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [HANDLE_W-1:0]     sorted_handle;
  logic signed [KEY_W-1:0] sorted_key;
  logic                    end_of_list;
  logic                    overflowed;

  modport source (output valid, sorted_handle, sorted_key, end_of_list, overflowed,
                  input ready);
  modport sink   (input valid, sorted_handle, sorted_key, end_of_list, overflowed,
                  output ready);
endinterface

FILE: src/dos_cell.sv
module dos_cell
  import dos_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  entry_t    new_entry,
  input  entry_t    left_entry,
  input  logic      left_after,
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      after
);

  // An empty cell counts as lying behind the arriving entry.
  assign after = !occupied || goes_after(entry, new_entry);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (after) begin
        entry <= left_after ? left_entry : new_entry;
      end
    end else if (ctl.shift) begin
      entry <= right_entry;
    end
  end

endmodule

FILE: src/depth_order_sorter.sv
// Each accepted entry is placed into the sorted cell chain in the cycle it transfers; an entry
// taken while full is dropped and sets the overflow bit. After the final entry, the first
// result is offered in the next cycle; results leave one per cycle while the sink is ready.
// No entry is taken while a list is being emitted; the next list starts after the last result.
// Reset clears the entry count, the overflow bit and the state; stored entries stay undefined.
module depth_order_sorter
  import dos_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
  input logic     clk,
  input logic     rst,
  dos_in_if.sink  entries,
  dos_out_if.source results
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic LOAD = 1'b0;
  localparam logic EMIT = 1'b1;

  logic             state;
  logic [CNT_W-1:0] count;
  logic             ovf;

  logic      in_xfer;
  logic      out_xfer;
  logic      full;
  cell_ctl_t ctl;
  entry_t    new_entry;

  entry_t cells [MAX_ENTRIES];
  logic   after [MAX_ENTRIES];

  assign full      = (count == CNT_W'(MAX_ENTRIES));
  assign in_xfer   = entries.valid && entries.ready;
  assign out_xfer  = results.valid && results.ready;
  assign ctl.insert = in_xfer && !full;
  assign ctl.shift  = out_xfer;

  assign new_entry.handle = entries.handle;
  assign new_entry.key    = entries.depth_key;
  assign new_entry.flag   = entries.on_top;

  assign entries.ready = (state == LOAD);

  genvar i;
  generate
    for (i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_t left_e;
      entry_t right_e;
      logic   left_a;
      if (i == 0) begin : g_head
        assign left_e = new_entry;
        assign left_a = 1'b0;
      end else begin : g_mid
        assign left_e = cells[i-1];
        assign left_a = after[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_tail
        assign right_e = cells[i];
      end else begin : g_body
        assign right_e = cells[i+1];
      end
      dos_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (CNT_W'(i) < count),
        .new_entry  (new_entry),
        .left_entry (left_e),
        .left_after (left_a),
        .right_entry(right_e),
        .entry      (cells[i]),
        .after      (after[i])
      );
    end
  endgenerate

  assign results.valid         = (state == EMIT);
  assign results.sorted_handle = cells[0].handle;
  assign results.sorted_key    = cells[0].key;
  assign results.end_of_list   = (count == CNT_W'(1));
  assign results.overflowed    = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (in_xfer) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
            if (entries.final_entry) begin
              state <= EMIT;
            end
          end
        end
        EMIT: begin
          if (out_xfer) begin
            count <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state <= LOAD;
              ovf   <= 1'b0;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> count != '0)
    else $error("emitting from an empty list");

  a_drop_sets_ovf: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && full) |=> ovf)
    else $error("dropped entry did not set overflow");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && results.end_of_list) |=> (state == LOAD && count == '0 && !ovf))
    else $error("list not cleared after last result");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.insert |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not advance count");

endmodule
